### rtl/clgc_pkg.sv
package clgc_pkg;

   localparam int LEVEL_WIDTH     = 7;
   localparam int DELAY_WIDTH     = 8;
   localparam int LIGHT_COUNT     = 3;
   localparam int SPOT_COUNT      = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [DELAY_WIDTH-1:0] OFF_DELAY_RESET  = 8'd60;
   localparam logic [LEVEL_WIDTH-1:0] FULL_LEVEL_RESET = 7'd100;

   typedef enum logic [1:0] {
      OP_LEFT_DOOR   = 2'd0,
      OP_RIGHT_DOOR  = 2'd1,
      OP_SECOND_TICK = 2'd2,
      OP_FADE_TICK   = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OFF_DELAY  = 1'b0,
      CSR_FULL_LEVEL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DELAY_WIDTH-1:0] off_delay_seconds;
      logic [LEVEL_WIDTH-1:0] full_level;
   } cfg_type;

   typedef struct packed {
      op_type operation;
      logic   door_open;
      logic   dome_switch_on;
      logic   left_button_pressed;
      logic   right_button_pressed;
      logic   key_on;
      logic   key_run;
   } item_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] dome_level;
      logic [LEVEL_WIDTH-1:0] left_level;
      logic [LEVEL_WIDTH-1:0] right_level;
      logic [DELAY_WIDTH-1:0] left_delay;
      logic [DELAY_WIDTH-1:0] right_delay;
      logic [LIGHT_COUNT-1:0] fading_mask;
   } result_type;

   // light index 0 is the dome, 1 driver spot, 2 passenger spot;
   // spot-only fields use index 0 driver, 1 passenger
   typedef struct packed {
      logic [LIGHT_COUNT-1:0][LEVEL_WIDTH-1:0] level;
      logic [LIGHT_COUNT-1:0]                  glow_up;
      logic [LIGHT_COUNT-1:0]                  glow_active;
      logic [SPOT_COUNT-1:0]                   door_triggered;
      logic [SPOT_COUNT-1:0][DELAY_WIDTH-1:0]  delay;
      logic [SPOT_COUNT-1:0]                   button_last;
      logic                                    dome_switch_last;
      logic                                    key_on_last;
      logic                                    key_run_last;
   } state_type;

endpackage

### rtl/clgc_csr.sv
module clgc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [clgc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [clgc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output clgc_pkg::cfg_type                    cfg
);
   import clgc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_OFF_DELAY: begin
               cfg_in.off_delay_seconds = csr_write_data[DELAY_WIDTH-1:0];
            end
            CSR_FULL_LEVEL: begin
               cfg_in.full_level = csr_write_data[LEVEL_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.off_delay_seconds <= OFF_DELAY_RESET;
         cfg_ff.full_level        <= FULL_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/clgc_in_stage.sv
module clgc_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  clgc_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output clgc_pkg::item_type item
);
   import clgc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // free when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/clgc_glow_engine.sv
module clgc_glow_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  clgc_pkg::cfg_type    cfg,
   input  clgc_pkg::item_type   item,
   input  logic                 advance,
   output clgc_pkg::result_type result
);
   import clgc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      logic                  side;
      logic [1:0]            li;
      logic [SPOT_COUNT-1:0] btn;

      side     = item.operation[0];
      li       = {1'b0, side} + 2'd1;
      btn      = {item.right_button_pressed, item.left_button_pressed};
      state_in = state_ff;

      unique case (item.operation)
         OP_LEFT_DOOR, OP_RIGHT_DOOR: begin
            state_in.glow_active[li] = 1'b1;
            if (item.door_open) begin
               state_in.glow_up[li]          = 1'b1;
               state_in.door_triggered[side] = 1'b1;
               if (state_ff.delay[side] != '0) begin
                  state_in.delay[side] = cfg.off_delay_seconds;
               end
            end else begin
               // hold at full after close with engine on but not cranked
               if (state_ff.key_on_last && !state_ff.key_run_last &&
                   state_ff.door_triggered[side] &&
                   state_ff.level[li] == cfg.full_level) begin
                  state_in.delay[side] = cfg.off_delay_seconds;
               end
               state_in.glow_up[li] = 1'b0;
            end
         end

         OP_SECOND_TICK: begin
            for (int s = 0; s < SPOT_COUNT; s++) begin
               if (!state_ff.key_on_last) begin
                  state_in.delay[s] = '0;
               end else if (state_ff.delay[s] != '0) begin
                  state_in.delay[s] = state_ff.delay[s] - 8'd1;
               end
            end
         end

         OP_FADE_TICK: begin
            if (item.dome_switch_on != state_ff.dome_switch_last) begin
               state_in.glow_active[0]   = 1'b1;
               state_in.glow_up[0]       = item.dome_switch_on;
               state_in.dome_switch_last = item.dome_switch_on;
            end
            state_in.key_on_last = item.key_on;

            if (item.key_run != state_ff.key_run_last) begin
               state_in.key_run_last = item.key_run;
               for (int s = 0; s < SPOT_COUNT; s++) begin
                  if (state_in.delay[s] != '0) begin
                     state_in.delay[s]       = '0;
                     state_in.glow_up[s + 1] = 1'b0;
                  end
               end
            end

            for (int s = 0; s < SPOT_COUNT; s++) begin
               if (btn[s] && !state_ff.button_last[s]) begin
                  if (state_in.level[s + 1] != '0 && state_in.delay[s] != '0) begin
                     state_in.delay[s]       = '0;
                     state_in.glow_up[s + 1] = 1'b0;
                  end else begin
                     state_in.glow_up[s + 1] = !state_in.glow_up[s + 1];
                  end
                  state_in.glow_active[s + 1] = 1'b1;
               end
               state_in.button_last[s] = btn[s];
            end

            // one fade step per active light; spots glowing down hold while a delay runs
            for (int i = 0; i < LIGHT_COUNT; i++) begin
               if (state_in.glow_active[i]) begin
                  if (state_in.glow_up[i]) begin
                     if (state_in.level[i] < cfg.full_level) begin
                        state_in.level[i] = state_in.level[i] + 7'd1;
                        if (state_in.level[i] >= cfg.full_level) begin
                           state_in.glow_active[i] = 1'b0;
                        end
                     end
                  end else if (state_in.level[i] != '0) begin
                     if (i == 0 || state_in.delay[(i == 0) ? 0 : i - 1] == '0) begin
                        state_in.level[i] = state_in.level[i] - 7'd1;
                        if (state_in.level[i] == '0) begin
                           state_in.glow_active[i] = 1'b0;
                        end
                     end
                  end
               end
            end
         end

         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign result.dome_level  = state_in.level[0];
   assign result.left_level  = state_in.level[1];
   assign result.right_level = state_in.level[2];
   assign result.left_delay  = state_in.delay[0];
   assign result.right_delay = state_in.delay[1];
   assign result.fading_mask = state_in.glow_active;

endmodule

### rtl/clgc_out_stage.sv
module clgc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  clgc_pkg::result_type result,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output clgc_pkg::result_type rsp_result
);
   import clgc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

### rtl/cabin_light_glow_controller_core.sv
// Cabin light glow controller: fades a dome light and two door spotlights.
//
// Request channel (req_*): one beat per event - left door, right door,
// one-second tick, or fade tick carrying sampled switch/button/ignition levels.
// Response channel (rsp_*): exactly one beat per request beat, in order,
// carrying all three levels, both off-delay counters and the fading mask.
// CSR port (csr_*): write-only, no wait; index 0 off-delay seconds,
// index 1 full level. Write only while no beats are in flight.
//
// Path: a request accepted on req_* is held in the input register, then
// one pass of update logic writes its result into the response register.
// Throughput: one beat per cycle while the receiver keeps rsp_ready high.
// A stalled receiver holds the response register; the input register still
// takes one more beat, after which req_ready drops until rsp_ready returns.
// Reset (synchronous) empties both registers, zeroes all light state and
// loads the CSRs with 60 seconds and full level 100.
module cabin_light_glow_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic                                 req_door_open,
   input  logic                                 req_dome_switch_on,
   input  logic                                 req_left_button_pressed,
   input  logic                                 req_right_button_pressed,
   input  logic                                 req_key_on,
   input  logic                                 req_key_run,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [clgc_pkg::LEVEL_WIDTH-1:0]     rsp_dome_level,
   output logic [clgc_pkg::LEVEL_WIDTH-1:0]     rsp_left_level,
   output logic [clgc_pkg::LEVEL_WIDTH-1:0]     rsp_right_level,
   output logic [clgc_pkg::DELAY_WIDTH-1:0]     rsp_left_delay,
   output logic [clgc_pkg::DELAY_WIDTH-1:0]     rsp_right_delay,
   output logic [clgc_pkg::LIGHT_COUNT-1:0]     rsp_fading_mask,

   input  logic                                 csr_write_enable,
   input  logic [clgc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [clgc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import clgc_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       room;
   logic       advance;
   result_type result;
   result_type rsp_result;

   assign req_item.operation            = op_type'(req_operation);
   assign req_item.door_open            = req_door_open;
   assign req_item.dome_switch_on       = req_dome_switch_on;
   assign req_item.left_button_pressed  = req_left_button_pressed;
   assign req_item.right_button_pressed = req_right_button_pressed;
   assign req_item.key_on               = req_key_on;
   assign req_item.key_run              = req_key_run;

   // the held event commits to light state when the response slot frees up
   assign advance = item_valid && room;

   clgc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   clgc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   clgc_glow_engine u_glow_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   clgc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_dome_level  = rsp_result.dome_level;
   assign rsp_left_level  = rsp_result.left_level;
   assign rsp_right_level = rsp_result.right_level;
   assign rsp_left_delay  = rsp_result.left_delay;
   assign rsp_right_delay = rsp_result.right_delay;
   assign rsp_fading_mask = rsp_result.fading_mask;

endmodule

### rtl/clgc_checker.sv
module clgc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [clgc_pkg::LEVEL_WIDTH-1:0]     rsp_dome_level,
   input logic [clgc_pkg::LEVEL_WIDTH-1:0]     rsp_left_level
);

   // after reset both registers are empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // back-to-back response beats: a level moves at most one step
   a_dome_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid && rsp_ready) && !$past(reset)) |->
         (rsp_dome_level == $past(rsp_dome_level) ||
          rsp_dome_level == $past(rsp_dome_level) + 7'd1 ||
          rsp_dome_level + 7'd1 == $past(rsp_dome_level)))
      else $error("dome level jumped");

   a_left_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid && rsp_ready) && !$past(reset)) |->
         (rsp_left_level == $past(rsp_left_level) ||
          rsp_left_level == $past(rsp_left_level) + 7'd1 ||
          rsp_left_level + 7'd1 == $past(rsp_left_level)))
      else $error("left level jumped");

endmodule

bind cabin_light_glow_controller_core clgc_checker u_clgc_checker (.*);

### tb/cabin_light_glow_controller_core_test.sv
`timescale 1ns / 100ps

module cabin_light_glow_controller_core_test;
   import clgc_pkg::*;

   // cycles with no beat on either channel before the run is called hung
   localparam int STALL_LIMIT = 2000;

   // one row of the directed walk: either a register write or a request beat,
   // the latter optionally carrying a hand-typed response
   typedef struct packed {
      bit                          is_write;
      csr_index_type               reg_index;
      logic [CSR_DATA_WIDTH-1:0]   reg_value;
      item_type                    beat;
      bit                          typed;
      result_type                  want;
   } glow_row_type;

   localparam item_type   NO_BEAT  = '0;
   localparam result_type NO_CHECK = '0;

   // beat bits after the op: {door, dome, left btn, right btn, ign on, ign run}
   localparam glow_row_type DIRECTED [29] = '{
      // straight out of reset nothing moves
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_SECOND_TICK, 6'b000000}, 1'b1,
        '{7'd0, 7'd0, 7'd0, 8'd0, 8'd0, 3'b000}},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b000000}, 1'b1,
        '{7'd0, 7'd0, 7'd0, 8'd0, 8'd0, 3'b000}},
      // door open with every sampled level high: a door beat ignores them
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_LEFT_DOOR, 6'b111111}, 1'b1,
        '{7'd0, 7'd0, 7'd0, 8'd0, 8'd0, 3'b010}},
      // dome switch on, ignition on: dome and driver spot both step up
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b010010}, 1'b1,
        '{7'd1, 7'd1, 7'd0, 8'd0, 8'd0, 3'b011}},
      '{1'b1, CSR_FULL_LEVEL, 8'd1, NO_BEAT, 1'b0, NO_CHECK},
      // close at full with ignition on: the reset delay of 60 s loads
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_LEFT_DOOR, 6'b000000}, 1'b1,
        '{7'd1, 7'd1, 7'd0, 8'd60, 8'd0, 3'b011}},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_SECOND_TICK, 6'b000000}, 1'b0, NO_CHECK},
      '{1'b1, CSR_OFF_DELAY, 8'd2, NO_BEAT, 1'b0, NO_CHECK},
      '{1'b1, CSR_FULL_LEVEL, 8'd3, NO_BEAT, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_RIGHT_DOOR, 6'b100000}, 1'b0, NO_CHECK},
      // spot held by its running delay
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b010010}, 1'b0, NO_CHECK},
      // reopen reloads the running delay
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_LEFT_DOOR, 6'b100000}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b010010}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b010010}, 1'b0, NO_CHECK},
      // up glow requested while already at full: stays active, no step
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_RIGHT_DOOR, 6'b100000}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_LEFT_DOOR, 6'b000000}, 1'b0, NO_CHECK},
      // driver button cancels the running delay
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b011010}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_RIGHT_DOOR, 6'b000000}, 1'b0, NO_CHECK},
      // ignition-run edge clears the passenger delay
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b010011}, 1'b0, NO_CHECK},
      // passenger button with no delay flips direction
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b010111}, 1'b0, NO_CHECK},
      // full level of zero: glow-up can never step
      '{1'b1, CSR_FULL_LEVEL, 8'd0, NO_BEAT, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_LEFT_DOOR, 6'b100000}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b000111}, 1'b0, NO_CHECK},
      // level above the lowered full level: glow-up holds it
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_RIGHT_DOOR, 6'b100000}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b000110}, 1'b0, NO_CHECK},
      '{1'b1, CSR_FULL_LEVEL, 8'd127, NO_BEAT, 1'b0, NO_CHECK},
      '{1'b1, CSR_OFF_DELAY, 8'd255, NO_BEAT, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_FADE_TICK, 6'b000110}, 1'b0, NO_CHECK},
      '{1'b0, CSR_OFF_DELAY, 8'd0, {OP_SECOND_TICK, 6'b000000}, 1'b0, NO_CHECK}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_operation = OP_LEFT_DOOR;
   logic                       req_door_open = 1'b0;
   logic                       req_dome_switch_on = 1'b0;
   logic                       req_left_button_pressed = 1'b0;
   logic                       req_right_button_pressed = 1'b0;
   logic                       req_key_on = 1'b0;
   logic                       req_key_run = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [LEVEL_WIDTH-1:0]     rsp_dome_level;
   logic [LEVEL_WIDTH-1:0]     rsp_left_level;
   logic [LEVEL_WIDTH-1:0]     rsp_right_level;
   logic [DELAY_WIDTH-1:0]     rsp_left_delay;
   logic [DELAY_WIDTH-1:0]     rsp_right_delay;
   logic [LIGHT_COUNT-1:0]     rsp_fading_mask;

   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_OFF_DELAY;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   cabin_light_glow_controller_core dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_operation            (req_operation),
      .req_door_open            (req_door_open),
      .req_dome_switch_on       (req_dome_switch_on),
      .req_left_button_pressed  (req_left_button_pressed),
      .req_right_button_pressed (req_right_button_pressed),
      .req_key_on               (req_key_on),
      .req_key_run              (req_key_run),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_dome_level           (rsp_dome_level),
      .rsp_left_level           (rsp_left_level),
      .rsp_right_level          (rsp_right_level),
      .rsp_left_delay           (rsp_left_delay),
      .rsp_right_delay          (rsp_right_delay),
      .rsp_fading_mask          (rsp_fading_mask),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Glow predictor: its own copy of the light state and both registers.
   // Light index 0 is the dome, 1 driver spot, 2 passenger spot; spot
   // arrays use 0 driver, 1 passenger.
   // ------------------------------------------------------------------
   bit [LEVEL_WIDTH-1:0] glow_level   [LIGHT_COUNT];
   bit                   glow_rising  [LIGHT_COUNT];
   bit                   glow_busy    [LIGHT_COUNT];
   bit                   door_lit     [SPOT_COUNT];
   bit [DELAY_WIDTH-1:0] spot_delay   [SPOT_COUNT];
   bit                   button_seen  [SPOT_COUNT];
   bit                   dome_seen;
   bit                   ign_on_seen;
   bit                   ign_run_seen;
   bit [DELAY_WIDTH-1:0] glow_off_delay = OFF_DELAY_RESET;
   bit [LEVEL_WIDTH-1:0] glow_full      = FULL_LEVEL_RESET;

   result_type expected_glow [$];
   int         mismatches = 0;
   int         quiet_cycles = 0;
   int         gap_percent = 22;

   // sticky levels for the random part, so switches and ignition behave like
   // real inputs instead of flickering every beat
   bit drv_dome, drv_left, drv_right, drv_ign_on, drv_ign_run;

   // courtesy button rising edge: cancel a running delay, else flip direction
   function automatic void press_button(int s, bit pressed);
      if (pressed && !button_seen[s]) begin
         if (glow_level[s + 1] != 0 && spot_delay[s] != 0) begin
            spot_delay[s] = 0;
            glow_rising[s + 1] = 1'b0;
         end else begin
            glow_rising[s + 1] = !glow_rising[s + 1];
         end
         glow_busy[s + 1] = 1'b1;
      end
      button_seen[s] = pressed;
   endfunction

   function automatic result_type advance_glow(item_type it);
      result_type r;
      int         s;
      case (it.operation)
         OP_LEFT_DOOR, OP_RIGHT_DOOR: begin
            s = (it.operation == OP_RIGHT_DOOR) ? 1 : 0;
            glow_busy[s + 1] = 1'b1;
            if (it.door_open) begin
               glow_rising[s + 1] = 1'b1;
               door_lit[s] = 1'b1;
               if (spot_delay[s] != 0) spot_delay[s] = glow_off_delay;
            end else begin
               // off-delay only when ignition on, engine not running, lit by
               // the door and sitting exactly at full
               if (ign_on_seen && !ign_run_seen && door_lit[s] &&
                   glow_level[s + 1] == glow_full)
                  spot_delay[s] = glow_off_delay;
               glow_rising[s + 1] = 1'b0;
            end
         end
         OP_SECOND_TICK: begin
            for (int k = 0; k < SPOT_COUNT; k++) begin
               if (!ign_on_seen) spot_delay[k] = 0;
               if (spot_delay[k] != 0) spot_delay[k]--;
            end
         end
         default: begin
            if (it.dome_switch_on != dome_seen) begin
               glow_busy[0] = 1'b1;
               glow_rising[0] = it.dome_switch_on;
               dome_seen = it.dome_switch_on;
            end
            ign_on_seen = it.key_on;
            if (it.key_run != ign_run_seen) begin
               ign_run_seen = it.key_run;
               for (int k = 0; k < SPOT_COUNT; k++) begin
                  if (spot_delay[k] != 0) begin
                     spot_delay[k] = 0;
                     glow_rising[k + 1] = 1'b0;
                  end
               end
            end
            press_button(0, it.left_button_pressed);
            press_button(1, it.right_button_pressed);
            // one fade step per active light; a spot glowing down waits out
            // its delay
            for (int li = 0; li < LIGHT_COUNT; li++) begin
               if (glow_busy[li]) begin
                  if (glow_rising[li]) begin
                     if (glow_level[li] < glow_full) begin
                        glow_level[li]++;
                        if (glow_level[li] >= glow_full) glow_busy[li] = 1'b0;
                     end
                  end else if (glow_level[li] != 0) begin
                     if ((li == 0) || (spot_delay[li - 1] == 0)) begin
                        glow_level[li]--;
                        if (glow_level[li] == 0) glow_busy[li] = 1'b0;
                     end
                  end
               end
            end
         end
      endcase
      r.dome_level  = glow_level[0];
      r.left_level  = glow_level[1];
      r.right_level = glow_level[2];
      r.left_delay  = spot_delay[0];
      r.right_delay = spot_delay[1];
      r.fading_mask = {glow_busy[2], glow_busy[1], glow_busy[0]};
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side. Tasks are entered at a rising edge and return at the
   // rising edge where their beat or write took effect.
   // ------------------------------------------------------------------
   task automatic send_glow_beat(item_type it, bit typed, result_type want);
      result_type predicted;
      while ($urandom_range(99) < gap_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_operation            <= it.operation;
      req_door_open            <= it.door_open;
      req_dome_switch_on       <= it.dome_switch_on;
      req_left_button_pressed  <= it.left_button_pressed;
      req_right_button_pressed <= it.right_button_pressed;
      req_key_on               <= it.key_on;
      req_key_run              <= it.key_run;
      do @(posedge clock); while (!req_ready);
      predicted = advance_glow(it);
      expected_glow.push_back(typed ? want : predicted);
   endtask

   // hold off until every outstanding response beat is back; checked on the
   // falling edge so it never races the response monitor
   task automatic drain_glow();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_glow.size() != 0);
      @(posedge clock);
   endtask

   // registers only change with the pipe empty
   task automatic write_glow_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      drain_glow();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_OFF_DELAY) glow_off_delay = value;
      else glow_full = value[LEVEL_WIDTH-1:0];
   endtask

   // Random phase: mostly plausible traffic (fade ticks carrying slowly
   // changing switch/ignition levels, doors, second ticks), some pure noise.
   task automatic run_glow_phase(logic [DELAY_WIDTH-1:0] off_delay,
                                 logic [LEVEL_WIDTH-1:0] full, int beats);
      item_type it;
      int       roll;
      write_glow_reg(CSR_OFF_DELAY, off_delay);
      write_glow_reg(CSR_FULL_LEVEL, {1'b0, full});
      for (int n = 0; n < beats; n++) begin
         if ($urandom_range(99) < 10) begin
            it.operation            = op_type'($urandom_range(3));
            it.door_open            = 1'($urandom_range(1));
            it.dome_switch_on       = 1'($urandom_range(1));
            it.left_button_pressed  = 1'($urandom_range(1));
            it.right_button_pressed = 1'($urandom_range(1));
            it.key_on               = 1'($urandom_range(1));
            it.key_run              = 1'($urandom_range(1));
         end else begin
            roll = $urandom_range(99);
            if (roll < 50)      it.operation = OP_FADE_TICK;
            else if (roll < 70) it.operation = OP_SECOND_TICK;
            else if (roll < 85) it.operation = OP_LEFT_DOOR;
            else                it.operation = OP_RIGHT_DOOR;
            if ($urandom_range(99) < 12) drv_dome = !drv_dome;
            if ($urandom_range(99) < 25) drv_left = !drv_left;
            if ($urandom_range(99) < 25) drv_right = !drv_right;
            if ($urandom_range(99) < (drv_ign_on ? 4 : 40)) drv_ign_on = !drv_ign_on;
            if ($urandom_range(99) < 8) drv_ign_run = !drv_ign_run;
            it.door_open            = 1'($urandom_range(1));
            it.dome_switch_on       = drv_dome;
            it.left_button_pressed  = drv_left;
            it.right_button_pressed = drv_right;
            it.key_on               = drv_ign_on;
            it.key_run              = drv_ign_run;
         end
         send_glow_beat(it, 1'b0, NO_CHECK);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random back-pressure, in-order compare per field.
   // ------------------------------------------------------------------
   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_glow.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               result_type exp_beat;
               exp_beat = expected_glow.pop_front();
               check_field("dome_level",  8'(exp_beat.dome_level),  8'(rsp_dome_level));
               check_field("left_level",  8'(exp_beat.left_level),  8'(rsp_left_level));
               check_field("right_level", 8'(exp_beat.right_level), 8'(rsp_right_level));
               check_field("left_delay",  exp_beat.left_delay,  rsp_left_delay);
               check_field("right_delay", exp_beat.right_delay, rsp_right_delay);
               check_field("fading_mask", 8'(exp_beat.fading_mask), 8'(rsp_fading_mask));
            end
         end
         rsp_ready <= ($urandom_range(99) >= gap_percent);
      end
   end

   // hang detector: any beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("cabin_light_glow_controller_core_test: errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < $size(DIRECTED); n++) begin
         if (DIRECTED[n].is_write)
            write_glow_reg(DIRECTED[n].reg_index, DIRECTED[n].reg_value);
         else
            send_glow_beat(DIRECTED[n].beat, DIRECTED[n].typed, DIRECTED[n].want);
      end

      // reset values, then the register extremes, then small full levels
      // where spots reach full often and the off-delay paths get exercised
      run_glow_phase(OFF_DELAY_RESET, FULL_LEVEL_RESET, 170);
      run_glow_phase(8'd0, 7'd127, 150);
      run_glow_phase(8'd255, 7'd1, 150);
      gap_percent = 0;   // back-to-back stretch on both channels
      run_glow_phase(8'd3, 7'd6, 180);
      gap_percent = 22;
      run_glow_phase(8'($urandom_range(1, 12)), 7'($urandom_range(2, 9)), 200);
      run_glow_phase(8'd1, 7'd2, 200);

      drain_glow();
      // two-stage pipe: give a stray extra beat time to show up
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("cabin_light_glow_controller_core_test: clean");
      else
         $display("cabin_light_glow_controller_core_test: errors");
      $finish;
   end

endmodule
